### rtl/rsi_pkg.sv
// ----------------------------------------------------------------------------
// rsi_pkg
// Types and constants shared by the ray versus segment intersection pipeline.
// ----------------------------------------------------------------------------
package rsi_pkg;

  localparam int COORD_BITS         = 16;
  localparam int FRACTION_ONE_BITS  = 16;

  // coordinate differences, products, determinants and point numerators
  localparam int DIFF_W = COORD_BITS + 1;
  localparam int PROD_W = 2 * COORD_BITS + 2;
  localparam int DET_W  = 2 * COORD_BITS + 3;
  localparam int NUM_W  = DET_W + DIFF_W + 1;
  localparam int REM_W  = NUM_W;

  // quotient bits, enough for the fraction range 0 .. 1.0 and for a point
  localparam int QUO_W = FRACTION_ONE_BITS + 1;

  localparam int FRONT_STAGES = 7;
  localparam int DIV_STEPS    = 2;
  localparam int DIV_STAGES   = (QUO_W + DIV_STEPS - 1) / DIV_STEPS;
  localparam int PIPE_STAGES  = FRONT_STAGES + DIV_STAGES + 1;

  localparam logic [QUO_W-1:0] FRACTION_ONE = QUO_W'(1) << FRACTION_ONE_BITS;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]     diff_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [DET_W-1:0]      det_t;
  typedef logic signed [NUM_W-1:0]      num_t;

  typedef struct packed {
    coord_t seg_start_x;
    coord_t seg_start_y;
    coord_t seg_end_x;
    coord_t seg_end_y;
    coord_t ray_origin_x;
    coord_t ray_origin_y;
    coord_t ray_dir_x;
    coord_t ray_dir_y;
  } rsi_req_t;

  typedef struct packed {
    logic             hit;
    logic             parallel;
    coord_t           hit_x;
    coord_t           hit_y;
    logic [QUO_W-1:0] seg_fraction;
  } rsi_rsp_t;

  // state carried through the divider stages
  typedef struct packed {
    logic             hit;
    logic             parallel;
    logic             sign_x;
    logic             sign_y;
    logic [DET_W-1:0] den;
    logic [REM_W-1:0] rem_x;
    logic [REM_W-1:0] rem_y;
    logic [REM_W-1:0] rem_f;
    logic [QUO_W-1:0] qx;
    logic [QUO_W-1:0] qy;
    logic [QUO_W-1:0] qf;
  } rsi_div_t;

endpackage

### rtl/rsi_stream_if.sv
// ----------------------------------------------------------------------------
// rsi_stream_if
// Valid/ready channel carrying one item of a given payload type.
// ----------------------------------------------------------------------------
interface rsi_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### rtl/rsi_front.sv
// ----------------------------------------------------------------------------
// rsi_front
// Determinant, numerators, hit decision and point numerators, seven stages.
// ----------------------------------------------------------------------------
module rsi_front import rsi_pkg::*; (
  input  logic                    clk_i,
  input  logic [FRONT_STAGES-1:0] en_i,
  input  rsi_req_t                req_i,
  output rsi_div_t                div_o
);

  typedef struct packed {
    coord_t x1, y1, dx, dy;
    diff_t  ex, ey, sx, sy, rx, ry;
  } s1_t;

  typedef struct packed {
    coord_t x1, y1;
    diff_t  ex, ey;
    prod_t  sy_dx, sx_dy, ry_dx, rx_dy, sy_rx, sx_ry;
  } s2_t;

  typedef struct packed {
    coord_t x1, y1;
    diff_t  ex, ey;
    det_t   den, tn, un;
  } s3_t;

  typedef struct packed {
    coord_t x1, y1;
    diff_t  ex, ey;
    det_t   dabs, tnn;
    logic   hit, par;
  } s4_t;

  typedef struct packed {
    logic hit, par;
    det_t dabs, tnn;
    num_t mx, mtx, my, mty;
  } s5_t;

  typedef struct packed {
    logic hit, par;
    det_t dabs, tnn;
    num_t nx, ny;
  } s6_t;

  s1_t      s1_d, s1_q;
  s2_t      s2_d, s2_q;
  s3_t      s3_d, s3_q;
  s4_t      s4_d, s4_q;
  s5_t      s5_d, s5_q;
  s6_t      s6_d, s6_q;
  rsi_div_t s7_d, s7_q;

  // differences
  always_comb begin
    s1_d.x1 = req_i.seg_start_x;
    s1_d.y1 = req_i.seg_start_y;
    s1_d.dx = req_i.ray_dir_x;
    s1_d.dy = req_i.ray_dir_y;
    s1_d.sx = DIFF_W'(req_i.seg_start_x) - DIFF_W'(req_i.seg_end_x);
    s1_d.sy = DIFF_W'(req_i.seg_start_y) - DIFF_W'(req_i.seg_end_y);
    s1_d.ex = DIFF_W'(req_i.seg_end_x) - DIFF_W'(req_i.seg_start_x);
    s1_d.ey = DIFF_W'(req_i.seg_end_y) - DIFF_W'(req_i.seg_start_y);
    s1_d.rx = DIFF_W'(req_i.seg_start_x) - DIFF_W'(req_i.ray_origin_x);
    s1_d.ry = DIFF_W'(req_i.seg_start_y) - DIFF_W'(req_i.ray_origin_y);
  end

  // cross products
  always_comb begin
    s2_d.x1    = s1_q.x1;
    s2_d.y1    = s1_q.y1;
    s2_d.ex    = s1_q.ex;
    s2_d.ey    = s1_q.ey;
    s2_d.sy_dx = PROD_W'(s1_q.sy) * PROD_W'(s1_q.dx);
    s2_d.sx_dy = PROD_W'(s1_q.sx) * PROD_W'(s1_q.dy);
    s2_d.ry_dx = PROD_W'(s1_q.ry) * PROD_W'(s1_q.dx);
    s2_d.rx_dy = PROD_W'(s1_q.rx) * PROD_W'(s1_q.dy);
    s2_d.sy_rx = PROD_W'(s1_q.sy) * PROD_W'(s1_q.rx);
    s2_d.sx_ry = PROD_W'(s1_q.sx) * PROD_W'(s1_q.ry);
  end

  always_comb begin
    s3_d.x1  = s2_q.x1;
    s3_d.y1  = s2_q.y1;
    s3_d.ex  = s2_q.ex;
    s3_d.ey  = s2_q.ey;
    s3_d.den = DET_W'(s2_q.sy_dx) - DET_W'(s2_q.sx_dy);
    s3_d.tn  = DET_W'(s2_q.ry_dx) - DET_W'(s2_q.rx_dy);
    s3_d.un  = DET_W'(s2_q.sy_rx) - DET_W'(s2_q.sx_ry);
  end

  // hit decision with the compares mirrored for a negative determinant
  always_comb begin
    logic pos, zero, ok_pos, ok_neg;
    pos    = !s3_q.den[DET_W-1];
    zero   = (s3_q.den == '0);
    ok_pos = !s3_q.tn[DET_W-1] && (s3_q.tn <= s3_q.den) && (s3_q.un > s3_q.den);
    ok_neg = (s3_q.tn[DET_W-1] || (s3_q.tn == '0)) && (s3_q.tn >= s3_q.den)
             && (s3_q.un < s3_q.den);
    s4_d.x1   = s3_q.x1;
    s4_d.y1   = s3_q.y1;
    s4_d.ex   = s3_q.ex;
    s4_d.ey   = s3_q.ey;
    s4_d.par  = zero;
    s4_d.hit  = !zero && (pos ? ok_pos : ok_neg);
    s4_d.dabs = pos ? s3_q.den : -s3_q.den;
    s4_d.tnn  = pos ? s3_q.tn : -s3_q.tn;
  end

  // point numerator terms: p1 * den + t_num * (p2 - p1)
  always_comb begin
    s5_d.hit  = s4_q.hit;
    s5_d.par  = s4_q.par;
    s5_d.dabs = s4_q.dabs;
    s5_d.tnn  = s4_q.tnn;
    s5_d.mx   = NUM_W'(s4_q.x1) * NUM_W'(s4_q.dabs);
    s5_d.my   = NUM_W'(s4_q.y1) * NUM_W'(s4_q.dabs);
    s5_d.mtx  = NUM_W'(s4_q.tnn) * NUM_W'(s4_q.ex);
    s5_d.mty  = NUM_W'(s4_q.tnn) * NUM_W'(s4_q.ey);
  end

  always_comb begin
    s6_d.hit  = s5_q.hit;
    s6_d.par  = s5_q.par;
    s6_d.dabs = s5_q.dabs;
    s6_d.tnn  = s5_q.tnn;
    s6_d.nx   = s5_q.mx + s5_q.mtx;
    s6_d.ny   = s5_q.my + s5_q.mty;
  end

  // magnitudes for the dividers, signs kept for truncation toward zero
  always_comb begin
    num_t ax, ay, sf;
    ax = s6_q.nx[NUM_W-1] ? -s6_q.nx : s6_q.nx;
    ay = s6_q.ny[NUM_W-1] ? -s6_q.ny : s6_q.ny;
    sf = NUM_W'(s6_q.tnn) << FRACTION_ONE_BITS;
    s7_d.hit      = s6_q.hit;
    s7_d.parallel = s6_q.par;
    s7_d.sign_x   = s6_q.nx[NUM_W-1];
    s7_d.sign_y   = s6_q.ny[NUM_W-1];
    s7_d.den      = s6_q.dabs;
    s7_d.rem_x    = REM_W'(ax);
    s7_d.rem_y    = REM_W'(ay);
    s7_d.rem_f    = REM_W'(sf);
    s7_d.qx       = '0;
    s7_d.qy       = '0;
    s7_d.qf       = '0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) s1_q <= s1_d;
    if (en_i[1]) s2_q <= s2_d;
    if (en_i[2]) s3_q <= s3_d;
    if (en_i[3]) s4_q <= s4_d;
    if (en_i[4]) s5_q <= s5_d;
    if (en_i[5]) s6_q <= s6_d;
    if (en_i[6]) s7_q <= s7_d;
  end

  assign div_o = s7_q;

endmodule

### rtl/rsi_div_stage.sv
// ----------------------------------------------------------------------------
// rsi_div_stage
// One register stage of the three parallel restoring dividers.
// ----------------------------------------------------------------------------
module rsi_div_stage import rsi_pkg::*; #(
  parameter int STAGE_IDX = 0
) (
  input  logic     clk_i,
  input  logic     en_i,
  input  rsi_div_t div_i,
  output rsi_div_t div_o
);

  localparam int TOP_BIT = QUO_W - 1 - STAGE_IDX * DIV_STEPS;

  rsi_div_t div_d, div_q;

  always_comb begin
    logic [REM_W-1:0] dsh;
    logic [REM_W:0]   dfx, dfy, dff;
    int               bitpos;
    div_d  = div_i;
    dsh    = '0;
    dfx    = '0;
    dfy    = '0;
    dff    = '0;
    bitpos = 0;
    for (int j = 0; j < DIV_STEPS; j++) begin
      bitpos = TOP_BIT - j;
      if (bitpos >= 0) begin
        dsh = REM_W'(div_d.den) << bitpos;
        dfx = {1'b0, div_d.rem_x} - {1'b0, dsh};
        dfy = {1'b0, div_d.rem_y} - {1'b0, dsh};
        dff = {1'b0, div_d.rem_f} - {1'b0, dsh};
        // no borrow means the shifted divisor fits: take the quotient bit
        if (!dfx[REM_W]) begin
          div_d.rem_x = dfx[REM_W-1:0];
          div_d.qx    = div_d.qx | (QUO_W'(1) << bitpos);
        end
        if (!dfy[REM_W]) begin
          div_d.rem_y = dfy[REM_W-1:0];
          div_d.qy    = div_d.qy | (QUO_W'(1) << bitpos);
        end
        if (!dff[REM_W]) begin
          div_d.rem_f = dff[REM_W-1:0];
          div_d.qf    = div_d.qf | (QUO_W'(1) << bitpos);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) div_q <= div_d;
  end

  assign div_o = div_q;

endmodule

### rtl/rsi_out_stage.sv
// ----------------------------------------------------------------------------
// rsi_out_stage
// Restores the point signs, clears the fields of a miss, output register.
// ----------------------------------------------------------------------------
module rsi_out_stage import rsi_pkg::*; (
  input  logic     clk_i,
  input  logic     en_i,
  input  rsi_div_t div_i,
  output rsi_rsp_t rsp_o
);

  rsi_rsp_t rsp_d, rsp_q;

  always_comb begin
    logic [QUO_W-1:0] px, py;
    px = div_i.sign_x ? -div_i.qx : div_i.qx;
    py = div_i.sign_y ? -div_i.qy : div_i.qy;
    rsp_d.hit          = div_i.hit;
    rsp_d.parallel     = div_i.parallel;
    rsp_d.hit_x        = div_i.hit ? coord_t'(px[COORD_BITS-1:0]) : '0;
    rsp_d.hit_y        = div_i.hit ? coord_t'(py[COORD_BITS-1:0]) : '0;
    rsp_d.seg_fraction = div_i.hit ? div_i.qf : '0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) rsp_q <= rsp_d;
  end

  assign rsp_o = rsp_q;

endmodule

### rtl/ray_segment_intersection_top.sv
// ----------------------------------------------------------------------------
// ray_segment_intersection_top
// 2D ray versus segment hit test with intersection point and segment fraction.
// ----------------------------------------------------------------------------
// stages: 7 arithmetic stages, 9 divider stages at 2 quotient bits each and 1
//   output register between an accepted input item and its result item
// throughput: one item per cycle; each stage stalls only when it holds an item
//   that the next stage cannot take, so bubbles close up under back-pressure
// reset: asynchronous, clears the stage valid bits only; no other state
module ray_segment_intersection_top import rsi_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  rsi_stream_if.sink   req_i,
  rsi_stream_if.source rsp_o
);

  localparam int LAST = PIPE_STAGES - 1;

  logic [PIPE_STAGES-1:0] vld_d, vld_q, vld_in, adv;
  rsi_div_t               div_pipe [DIV_STAGES+1];
  rsi_rsp_t               rsp;

  // a stage may load when empty or when its item moves on
  assign adv[LAST] = !vld_q[LAST] || rsp_o.ready;
  for (genvar k = 0; k < LAST; k++) begin : g_adv
    assign adv[k] = !vld_q[k] || adv[k+1];
  end

  assign vld_in = {vld_q[LAST-1:0], req_i.valid};
  assign vld_d  = (adv & vld_in) | (~adv & vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  rsi_front u_front (
    .clk_i (clk_i),
    .en_i  (adv[FRONT_STAGES-1:0]),
    .req_i (req_i.payload),
    .div_o (div_pipe[0])
  );

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    rsi_div_stage #(
      .STAGE_IDX (k)
    ) u_div (
      .clk_i (clk_i),
      .en_i  (adv[FRONT_STAGES+k]),
      .div_i (div_pipe[k]),
      .div_o (div_pipe[k+1])
    );
  end

  rsi_out_stage u_out (
    .clk_i (clk_i),
    .en_i  (adv[LAST]),
    .div_i (div_pipe[DIV_STAGES]),
    .rsp_o (rsp)
  );

  assign req_i.ready   = adv[0];
  assign rsp_o.valid   = vld_q[LAST];
  assign rsp_o.payload = rsp;

  a_hit_not_parallel : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> !(rsp_o.payload.hit && rsp_o.payload.parallel))
    else $error("hit reported on a zero determinant");

  a_miss_fields_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && !rsp_o.payload.hit) |->
      (rsp_o.payload.hit_x == '0 && rsp_o.payload.hit_y == '0 &&
       rsp_o.payload.seg_fraction == '0))
    else $error("miss item carries nonzero point or fraction");

  a_fraction_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.payload.hit) |-> (rsp_o.payload.seg_fraction <= FRACTION_ONE))
    else $error("segment fraction above 1.0 on a hit");

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stand-alone testbench for ray_segment_intersection_top. Directed rays cover
// parallel and degenerate input, the ends of the segment, the ray boundary
// and the field extremes. Random rays follow, most of them aimed to cross the
// segment. The sender runs in bursts and the receiver stalls. Each result is
// checked field by field against a predictor that runs in the testbench.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rsi_pkg::*;

  localparam int RANDOM_ITEMS = 1430;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 40;

  typedef enum int {RDY_ALWAYS, RDY_COIN, RDY_BURSTY} ready_mode_e;

  logic clk_i;
  logic rst_ni;

  rsi_stream_if #(.payload_t(rsi_req_t)) req_if ();
  rsi_stream_if #(.payload_t(rsi_rsp_t)) rsp_if ();

  ray_segment_intersection_top uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  rsi_req_t        pending_rays[$];
  rsi_rsp_t        crossing_q[$];
  int unsigned     errors;
  int unsigned     rays_taken;
  int unsigned     results_seen;
  int unsigned     hits_seen;
  int unsigned     parallels_seen;
  longint unsigned cycles;
  bit              req_taken;
  int              gap_left;
  int              burst_left;
  int              stall_left;
  int              mode_left;
  ready_mode_e     ready_mode;

  function automatic rsi_rsp_t predict_crossing(rsi_req_t r);
    longint   x1, y1, x2, y2, ox, oy, dx, dy;
    longint   sx, sy, rx, ry, den, tn, un, px, py, fr;
    rsi_rsp_t res;
    x1 = longint'(r.seg_start_x);
    y1 = longint'(r.seg_start_y);
    x2 = longint'(r.seg_end_x);
    y2 = longint'(r.seg_end_y);
    ox = longint'(r.ray_origin_x);
    oy = longint'(r.ray_origin_y);
    dx = longint'(r.ray_dir_x);
    dy = longint'(r.ray_dir_y);
    sx = x1 - x2;
    sy = y1 - y2;
    rx = x1 - ox;
    ry = y1 - oy;
    den = sy * dx - sx * dy;
    tn  = ry * dx - rx * dy;
    un  = sy * rx - sx * ry;
    res = '0;
    if (den == 0) begin
      res.parallel = 1'b1;
    end else begin
      // normalize so the compares need no division
      if (den < 0) begin
        den = -den;
        tn  = -tn;
        un  = -un;
      end
      if (tn >= 0 && tn <= den && un > den) begin
        // signed division truncates toward zero
        px = (x1 * den + tn * (x2 - x1)) / den;
        py = (y1 * den + tn * (y2 - y1)) / den;
        fr = (tn <<< FRACTION_ONE_BITS) / den;
        res.hit          = 1'b1;
        res.hit_x        = coord_t'(px);
        res.hit_y        = coord_t'(py);
        res.seg_fraction = QUO_W'(fr);
      end
    end
    return res;
  endfunction

  function automatic rsi_req_t mk_ray(int x1, int y1, int x2, int y2,
                                      int ox, int oy, int dx, int dy);
    rsi_req_t r;
    r.seg_start_x  = coord_t'(x1);
    r.seg_start_y  = coord_t'(y1);
    r.seg_end_x    = coord_t'(x2);
    r.seg_end_y    = coord_t'(y2);
    r.ray_origin_x = coord_t'(ox);
    r.ray_origin_y = coord_t'(oy);
    r.ray_dir_x    = coord_t'(dx);
    r.ray_dir_y    = coord_t'(dy);
    return r;
  endfunction

  function automatic int pick(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic int pick_span();
    case ($urandom_range(0, 2))
      0:       return 64;
      1:       return 1024;
      default: return 16000;
    endcase
  endfunction

  function automatic rsi_req_t random_ray();
    int sel, span, dspan, k, m, f;
    int x1, y1, x2, y2, px, py, dx, dy;
    sel = $urandom_range(0, 99);
    if (sel < 25) begin
      return rsi_req_t'({$urandom, $urandom, $urandom, $urandom});
    end
    if (sel < 37) begin
      // parallel or degenerate geometry
      x1 = pick(4000);
      y1 = pick(4000);
      x2 = pick(4000);
      y2 = pick(4000);
      case ($urandom_range(0, 2))
        0: begin
          k = pick(3);
          return mk_ray(x1, y1, x2, y2, pick(32000), pick(32000),
                        (x2 - x1) * k, (y2 - y1) * k);
        end
        1:       return mk_ray(x1, y1, x1, y1, pick(32000), pick(32000),
                               pick(32767), pick(32767));
        default: return mk_ray(x1, y1, x2, y2, pick(32000), pick(32000), 0, 0);
      endcase
    end
    // aimed ray: pick a point on the segment, back off along the direction
    span  = pick_span();
    dspan = (span == 16000) ? 2000 : span;
    x1 = pick(span);
    y1 = pick(span);
    x2 = pick(span);
    y2 = pick(span);
    f  = $urandom_range(0, 256);
    px = x1 + (x2 - x1) * f / 256;
    py = y1 + (y2 - y1) * f / 256;
    dx = pick(dspan);
    dy = pick(dspan);
    // u = m/4 at the crossing, so m = 4 sits on the boundary
    m  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 6) : $urandom_range(5, 16);
    return mk_ray(x1, y1, x2, y2, px - dx * m / 4, py - dy * m / 4, dx, dy);
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch on %s at result %0d: got %0d expected %0d",
             what, results_seen, got, want);
    errors++;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // sender: bursts of random length separated by random gaps
  always @(negedge clk_i) begin
    logic     nv;
    logic     nr;
    rsi_req_t np;
    if (rst_ni) begin
      nv = req_if.valid;
      np = req_if.payload;
      if (!req_if.valid || req_taken) begin
        nv = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_rays.size() > 0) begin
          np = pending_rays.pop_front();
          nv = 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
      end
      req_if.valid   <= nv;
      req_if.payload <= np;

      // receiver: stretches of full rate, coin flips and long stalls
      if (mode_left == 0) begin
        ready_mode = ready_mode_e'($urandom_range(0, 2));
        mode_left  = $urandom_range(20, 200);
      end else begin
        mode_left--;
      end
      case (ready_mode)
        RDY_ALWAYS: nr = 1'b1;
        RDY_COIN:   nr = 1'($urandom_range(0, 1));
        default: begin
          if (stall_left > 0) begin
            nr = 1'b0;
            stall_left--;
          end else begin
            nr = 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 20);
          end
        end
      endcase
      rsp_if.ready <= nr;
    end
  end

  always @(posedge clk_i) begin
    rsi_rsp_t want;
    rsi_rsp_t got;
    if (rst_ni) begin
      cycles++;
      req_taken = req_if.valid && req_if.ready;
      if (req_taken) begin
        crossing_q.push_back(predict_crossing(req_if.payload));
        rays_taken++;
      end
      if (rsp_if.valid && rsp_if.ready) begin
        got = rsp_if.payload;
        results_seen++;
        if (crossing_q.size() == 0) begin
          report_mismatch("unexpected item", 1, 0);
        end else begin
          want = crossing_q.pop_front();
          if (want.hit) hits_seen++;
          if (want.parallel) parallels_seen++;
          if (got.hit !== want.hit) report_mismatch("hit", got.hit, want.hit);
          if (got.parallel !== want.parallel)
            report_mismatch("parallel", got.parallel, want.parallel);
          if (got.hit_x !== want.hit_x)
            report_mismatch("hit_x", longint'(got.hit_x), longint'(want.hit_x));
          if (got.hit_y !== want.hit_y)
            report_mismatch("hit_y", longint'(got.hit_y), longint'(want.hit_y));
          if (got.seg_fraction !== want.seg_fraction)
            report_mismatch("seg_fraction", got.seg_fraction, want.seg_fraction);
        end
      end
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles, %0d items still expected",
                 cycles, crossing_q.size());
        $display("FAIL ray_segment_intersection_top");
        $finish;
      end
    end
  end

  initial begin
    rst_ni         = 1'b0;
    req_if.valid   = 1'b0;
    req_if.payload = '0;
    rsp_if.ready   = 1'b0;
    req_taken      = 1'b0;
    gap_left       = 0;
    burst_left     = 1;
    stall_left     = 0;
    mode_left      = 0;
    ready_mode     = RDY_ALWAYS;
    errors         = 0;
    cycles         = 0;

    // degenerate and parallel geometry
    pending_rays.push_back(mk_ray(100, 100, 100, 100, 0, 0, 16, 16));
    pending_rays.push_back(mk_ray(0, -160, 0, 160, -320, 0, 0, 0));
    pending_rays.push_back(mk_ray(0, 0, 160, 160, 0, 32, 16, 16));
    pending_rays.push_back(mk_ray(-32768, -32768, -32768, -32768,
                                  -32768, -32768, -32768, -32768));
    // plain crossing, both segment orientations
    pending_rays.push_back(mk_ray(0, -160, 0, 160, -320, 0, 16, 0));
    pending_rays.push_back(mk_ray(0, 160, 0, -160, -320, 0, 16, 0));
    // segment ends, and just past one
    pending_rays.push_back(mk_ray(0, 0, 0, 160, -320, 0, 16, 0));
    pending_rays.push_back(mk_ray(0, -160, 0, 0, -320, 0, 16, 0));
    pending_rays.push_back(mk_ray(0, 1, 0, 160, -320, 0, 16, 0));
    // ray boundary: crossing exactly at origin plus direction, then just beyond
    pending_rays.push_back(mk_ray(0, -160, 0, 160, -16, 0, 16, 0));
    pending_rays.push_back(mk_ray(0, -160, 0, 160, -16, 0, 15, 0));
    pending_rays.push_back(mk_ray(0, -160, 0, 160, 320, 0, 16, 0));
    // fractional crossing with negative point, checks truncation toward zero
    pending_rays.push_back(mk_ray(-3, -16, 0, 16, -100, 5, 16, 0));
    pending_rays.push_back(mk_ray(-50, -7, -20, -90, 40, -40, -16, 3));
    // field extremes
    pending_rays.push_back(mk_ray(-32768, 0, 32767, 0, 0, -32768, 0, 1));
    pending_rays.push_back(mk_ray(-32768, -32768, 32767, 32767,
                                  -32768, 32767, 32767, -32768));
    pending_rays.push_back(mk_ray(32767, -32768, -32768, 32767, 0, 0, 1, 1));
    pending_rays.push_back(mk_ray(32767, 32767, 32767, 32767,
                                  32767, 32767, 32767, 32767));
    pending_rays.push_back(mk_ray(32767, -32768, 32767, 32767,
                                  -32768, 0, 1, 0));
    pending_rays.push_back(mk_ray(-32768, 32767, 32767, 32767,
                                  0, -32768, -1, 1));
    for (int i = 0; i < RANDOM_ITEMS; i++) pending_rays.push_back(random_ray());

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_rays.size() > 0 || req_if.valid) @(posedge clk_i);
    while (crossing_q.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d rays in, %0d results out: %0d hits, %0d parallel, %0d misses",
             rays_taken, results_seen, hits_seen, parallels_seen,
             results_seen - hits_seen - parallels_seen);
    $display("%0d mismatches over %0d cycles", errors, cycles);
    if (errors == 0 && crossing_q.size() == 0) begin
      $display("PASS ray_segment_intersection_top");
    end else begin
      $display("FAIL ray_segment_intersection_top");
    end
    $finish;
  end

endmodule
